// File: design/lsw_pkg.sv
// ----------------------------------------------------------------------------
// lsw_pkg: shared types and constants of the L-system expansion walker
// Sizes of the rule table and the walk stack, handshake codes, and the
// structs that carry rule-store requests between the walker and the store.
// ----------------------------------------------------------------------------
package lsw_pkg;

  // Table and stack sizes.
  localparam int MAX_DEPTH    = 16;
  localparam int MAX_RULE_LEN = 64;
  localparam int SYM_W        = 8;
  localparam int NUM_SYMS     = 1 << SYM_W;

  // Fixed widths of the item fields and registers.
  localparam int KIND_W   = 2;
  localparam int CPOS_W   = 6;
  localparam int RLEN_W   = 7;
  localparam int DEPTH_W  = 5;
  localparam int STAT_W   = 2;

  // Derived widths, and fixed widths for comparison and saturation.
  localparam int LVL_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int POS_W   = $clog2(MAX_RULE_LEN + 2);
  localparam int LEN_W   = $clog2(MAX_RULE_LEN + 1);
  localparam int CH_W    = (MAX_RULE_LEN > 1) ? $clog2(MAX_RULE_LEN) : 1;
  localparam int CADDR_W = SYM_W + CH_W;
  localparam int CMP_W   = 8;
  localparam int SAT_W   = 10;

  // Reset values of the configuration registers.
  localparam logic [SYM_W-1:0]   START_RESET = 8'd65;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd1;

  // Configuration register indexes.
  localparam logic CFG_START = 1'b0;
  localparam logic CFG_DEPTH = 1'b1;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_WR_CHAR = 2'd0,
    KIND_SET_LEN = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NEXT    = 2'd3
  } kind_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK  = 2'd0,
    STAT_END = 2'd1,
    STAT_ERR = 2'd2
  } status_t;

  // Walker sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LEN,
    S_EVAL,
    S_PUT
  } state_t;

  // Write request into the rule store.
  typedef struct packed {
    logic             char_we;
    logic             len_we;
    logic [SYM_W-1:0] sym;
    logic [CH_W-1:0]  pos;
    logic [7:0]       char_value;
    logic [LEN_W-1:0] len;
  } rule_wr_t;

  // Read request into the rule store.
  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] rule;
    logic [CH_W-1:0]  pos;
  } rule_rd_t;

endpackage

// File: design/lsw_rule_store.sv
// ----------------------------------------------------------------------------
// lsw_rule_store: rule character memory, rule lengths and defined marks
// One write port and one registered read port per memory. The defined marks
// live in flip-flops that reset clears; an undefined rule reads length zero.
// ----------------------------------------------------------------------------
module lsw_rule_store (
  input  logic                           clk,
  input  logic                           rst,
  input  lsw_pkg::rule_wr_t              wr,
  input  lsw_pkg::rule_rd_t              rd,
  output logic [lsw_pkg::NUM_SYMS-1:0]   defined_bits,
  output logic [7:0]                     rd_char,
  output logic [lsw_pkg::LEN_W-1:0]      rd_len
);

  localparam int CHAR_DEPTH = lsw_pkg::NUM_SYMS * (1 << lsw_pkg::CH_W);

  logic [7:0]                char_mem [CHAR_DEPTH];
  logic [lsw_pkg::LEN_W-1:0] len_mem  [lsw_pkg::NUM_SYMS];
  logic [lsw_pkg::LEN_W-1:0] len_q;
  logic                      def_q;

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (wr.char_we) begin
      char_mem[{wr.sym, wr.pos}] <= wr.char_value;
    end
    if (wr.len_we) begin
      len_mem[wr.sym] <= wr.len;
    end
    if (rd.en) begin
      rd_char <= char_mem[{rd.rule, rd.pos}];
      len_q   <= len_mem[rd.rule];
      def_q   <= defined_bits[rd.rule];
    end
  end

  // Defined marks: cleared at reset, set by a length write.
  always_ff @(posedge clk) begin
    if (rst) begin
      defined_bits <= '0;
    end else if (wr.len_we) begin
      defined_bits[wr.sym] <= 1'b1;
    end
  end

  // A rule that was never given a length reads as empty.
  assign rd_len = def_q ? len_q : '0;

endmodule

// File: design/lsw_walker.sv
// ----------------------------------------------------------------------------
// lsw_walker: depth-first walk sequencer over the rule table
// Takes input words, issues rule-store writes, and steps the position stack
// one read and one evaluation at a time until a symbol or a status emerges.
// ----------------------------------------------------------------------------
module lsw_walker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lsw_pkg::KIND_W-1:0]    kind,
  input  logic [lsw_pkg::SYM_W-1:0]     rule_symbol,
  input  logic [lsw_pkg::CPOS_W-1:0]    char_position,
  input  logic [7:0]                    char_value,
  input  logic [lsw_pkg::RLEN_W-1:0]    rule_len,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lsw_pkg::SYM_W-1:0]     out_symbol,
  output logic [lsw_pkg::STAT_W-1:0]    status,
  input  logic [lsw_pkg::SYM_W-1:0]     start_symbol,
  input  logic [lsw_pkg::CMP_W-1:0]     depth_limit,
  output lsw_pkg::rule_wr_t             wr,
  output lsw_pkg::rule_rd_t             rd,
  input  logic [lsw_pkg::NUM_SYMS-1:0]  defined_bits,
  input  logic [7:0]                    rd_char,
  input  logic [lsw_pkg::LEN_W-1:0]     rd_len
);

  lsw_pkg::state_t state, state_next;

  // Walk state.
  logic [lsw_pkg::POS_W-1:0] stack_position [lsw_pkg::MAX_DEPTH];
  logic [lsw_pkg::SYM_W-1:0] stack_rule     [lsw_pkg::MAX_DEPTH];
  logic [lsw_pkg::LVL_W-1:0] level;
  logic [lsw_pkg::SYM_W-1:0] current_rule;
  logic                      finished;
  logic [lsw_pkg::POS_W-1:0] pos_q;

  // Pending result.
  logic [lsw_pkg::SYM_W-1:0] res_symbol;
  lsw_pkg::status_t          res_status;

  // Sequencer decisions.
  logic                      accept;
  logic                      do_restart;
  logic                      do_issue;
  logic                      do_pop;
  logic                      do_push;
  logic                      do_finish;
  logic                      do_result;
  logic                      do_out;
  logic [lsw_pkg::SYM_W-1:0] res_symbol_next;
  lsw_pkg::status_t          res_status_next;

  // Datapath terms.
  logic [lsw_pkg::LVL_W-1:0] level_up;
  logic [lsw_pkg::LVL_W-1:0] level_dn;
  logic [lsw_pkg::POS_W-1:0] pos_cur;
  logic [lsw_pkg::POS_W-1:0] pos_next;
  logic                      past_end;
  logic                      sym_defined;
  logic                      at_floor;
  logic                      start_defined;
  logic [lsw_pkg::SAT_W-1:0] len_wide;

  assign accept        = in_valid && in_ready;
  assign in_ready      = (state == lsw_pkg::S_IDLE);
  assign level_up      = level + lsw_pkg::LVL_W'(1);
  assign level_dn      = level - lsw_pkg::LVL_W'(1);
  assign pos_cur       = stack_position[level];
  assign pos_next      = pos_cur + lsw_pkg::POS_W'(1);
  assign past_end      = pos_q > lsw_pkg::POS_W'(rd_len);
  assign sym_defined   = defined_bits[rd_char];
  assign at_floor      = (lsw_pkg::CMP_W'(level) + lsw_pkg::CMP_W'(1)) >= depth_limit;
  assign start_defined = defined_bits[start_symbol];
  assign len_wide      = lsw_pkg::SAT_W'(rule_len);

  // Rule-store writes come straight from the accepted load word.
  always_comb begin
    wr            = '0;
    wr.sym        = rule_symbol;
    wr.pos        = lsw_pkg::CH_W'(char_position);
    wr.char_value = char_value;
    if (len_wide > lsw_pkg::SAT_W'(lsw_pkg::MAX_RULE_LEN)) begin
      wr.len = lsw_pkg::LEN_W'(lsw_pkg::MAX_RULE_LEN);
    end else begin
      wr.len = lsw_pkg::LEN_W'(rule_len);
    end
    if (accept && lsw_pkg::kind_t'(kind) == lsw_pkg::KIND_WR_CHAR) begin
      wr.char_we = lsw_pkg::SAT_W'(char_position) < lsw_pkg::SAT_W'(lsw_pkg::MAX_RULE_LEN);
    end
    if (accept && lsw_pkg::kind_t'(kind) == lsw_pkg::KIND_SET_LEN) begin
      wr.len_we = 1'b1;
    end
  end

  // Reads of the current rule at the next character position.
  always_comb begin
    rd      = '0;
    rd.en   = do_issue;
    rd.rule = current_rule;
    rd.pos  = lsw_pkg::CH_W'(pos_cur);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lsw_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and sequencer decisions.
  always_comb begin
    state_next      = state;
    do_restart      = 1'b0;
    do_issue        = 1'b0;
    do_pop          = 1'b0;
    do_push         = 1'b0;
    do_finish       = 1'b0;
    do_result       = 1'b0;
    do_out          = 1'b0;
    res_symbol_next = '0;
    res_status_next = lsw_pkg::STAT_OK;
    unique case (state)
      lsw_pkg::S_IDLE: begin
        if (accept) begin
          unique case (lsw_pkg::kind_t'(kind))
            lsw_pkg::KIND_WR_CHAR,
            lsw_pkg::KIND_SET_LEN: begin
              state_next = lsw_pkg::S_IDLE;
            end
            lsw_pkg::KIND_RESTART: begin
              if (start_defined) begin
                do_restart = 1'b1;
                state_next = lsw_pkg::S_LEN;
              end else begin
                do_result       = 1'b1;
                res_status_next = lsw_pkg::STAT_ERR;
                state_next      = lsw_pkg::S_PUT;
              end
            end
            lsw_pkg::KIND_NEXT: begin
              if (finished) begin
                do_result       = 1'b1;
                res_status_next = lsw_pkg::STAT_ERR;
                state_next      = lsw_pkg::S_PUT;
              end else begin
                state_next = lsw_pkg::S_LEN;
              end
            end
            default: state_next = lsw_pkg::S_IDLE;
          endcase
        end
      end
      lsw_pkg::S_LEN: begin
        do_issue   = 1'b1;
        state_next = lsw_pkg::S_EVAL;
      end
      lsw_pkg::S_EVAL: begin
        priority if (past_end && level == '0) begin
          do_finish       = 1'b1;
          do_result       = 1'b1;
          res_status_next = lsw_pkg::STAT_END;
          state_next      = lsw_pkg::S_PUT;
        end else if (past_end) begin
          do_pop     = 1'b1;
          state_next = lsw_pkg::S_LEN;
        end else if (!sym_defined || at_floor) begin
          do_result       = 1'b1;
          res_symbol_next = rd_char;
          res_status_next = lsw_pkg::STAT_OK;
          state_next      = lsw_pkg::S_PUT;
        end else begin
          do_push    = 1'b1;
          state_next = lsw_pkg::S_LEN;
        end
      end
      lsw_pkg::S_PUT: begin
        if (!out_valid || out_ready) begin
          do_out     = 1'b1;
          state_next = lsw_pkg::S_IDLE;
        end
      end
      default: state_next = lsw_pkg::S_IDLE;
    endcase
  end

  // Level, current rule and walk status.
  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= '0;
      current_rule <= '0;
      finished     <= 1'b1;
    end else begin
      if (do_restart) begin
        level        <= '0;
        current_rule <= start_symbol;
        finished     <= 1'b0;
      end
      if (do_pop) begin
        level        <= level_dn;
        current_rule <= stack_rule[level_dn];
      end
      if (do_push) begin
        level        <= level_up;
        current_rule <= rd_char;
      end
      if (do_finish) begin
        finished <= 1'b1;
      end
    end
  end

  // Position stack, rule stack and pending result.
  always_ff @(posedge clk) begin
    if (do_restart) begin
      stack_position[0] <= '0;
    end
    if (do_issue) begin
      stack_position[level] <= pos_next;
      pos_q                 <= pos_next;
    end
    if (do_push) begin
      stack_rule[level]        <= current_rule;
      stack_position[level_up] <= '0;
    end
    if (do_result) begin
      res_symbol <= res_symbol_next;
      res_status <= res_status_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_out) begin
      out_symbol <= res_symbol;
      status     <= res_status;
    end
  end

  // An evaluation always follows a rule-store read.
  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    state == lsw_pkg::S_EVAL |-> $past(state) == lsw_pkg::S_LEN)
    else $error("evaluation without a preceding rule read");

  // A new word on the output only comes from the result state.
  a_out_from_put: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == lsw_pkg::S_PUT)
    else $error("output word loaded outside the result state");

  // A symbol result is only produced while a walk is active.
  a_symbol_needs_walk: assert property (@(posedge clk) disable iff (rst)
    (state == lsw_pkg::S_PUT && res_status == lsw_pkg::STAT_OK) |-> !finished)
    else $error("symbol result with no active walk");

  // A next word after the end goes straight to an error result.
  a_next_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && lsw_pkg::kind_t'(kind) == lsw_pkg::KIND_NEXT && finished)
    |=> (state == lsw_pkg::S_PUT && res_status == lsw_pkg::STAT_ERR))
    else $error("next after the end did not answer error");

endmodule

// File: design/lsystem_expansion_walker_top.sv
// ----------------------------------------------------------------------------
// lsystem_expansion_walker_top: L-system string expansion walker
// Holds the rule table and walks the expansion of the start symbol depth
// first, one output word (a symbol or a status) per restart or next word.
// ----------------------------------------------------------------------------
// Rule character and rule length words produce no result. A restart or next
// word runs the walk sequencer: every walk step reads the rule store
// (character and length in parallel) in S_LEN and evaluates the read in
// S_EVAL, and each step either emits, pops a level or pushes a level. The
// input is not ready while a walk step runs, and a result waits in the output
// register while rule loads continue. The defined marks clear in the reset
// cycle, so no clearing pass is needed after reset.
module lsystem_expansion_walker_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [7:0]                    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lsw_pkg::KIND_W-1:0]    kind,
  input  logic [lsw_pkg::SYM_W-1:0]     rule_symbol,
  input  logic [lsw_pkg::CPOS_W-1:0]    char_position,
  input  logic [7:0]                    char_value,
  input  logic [lsw_pkg::RLEN_W-1:0]    rule_len,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lsw_pkg::SYM_W-1:0]     out_symbol,
  output logic [lsw_pkg::STAT_W-1:0]    status
);

  logic [lsw_pkg::SYM_W-1:0]    start_symbol;
  logic [lsw_pkg::DEPTH_W-1:0]  expansion_depth;
  logic [lsw_pkg::CMP_W-1:0]    depth_limit;
  lsw_pkg::rule_wr_t            wr;
  lsw_pkg::rule_rd_t            rd;
  logic [lsw_pkg::NUM_SYMS-1:0] defined_bits;
  logic [7:0]                   rd_char;
  logic [lsw_pkg::LEN_W-1:0]    rd_len;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_symbol    <= lsw_pkg::START_RESET;
      expansion_depth <= lsw_pkg::DEPTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsw_pkg::CFG_START: start_symbol    <= cfg_data;
        lsw_pkg::CFG_DEPTH: expansion_depth <= cfg_data[lsw_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Depth limit: zero acts as one, large values stop at the stack depth.
  always_comb begin
    priority if (expansion_depth == '0) begin
      depth_limit = lsw_pkg::CMP_W'(1);
    end else if (lsw_pkg::CMP_W'(expansion_depth) > lsw_pkg::CMP_W'(lsw_pkg::MAX_DEPTH)) begin
      depth_limit = lsw_pkg::CMP_W'(lsw_pkg::MAX_DEPTH);
    end else begin
      depth_limit = lsw_pkg::CMP_W'(expansion_depth);
    end
  end

  lsw_rule_store u_store (
    .clk          (clk),
    .rst          (rst),
    .wr           (wr),
    .rd           (rd),
    .defined_bits (defined_bits),
    .rd_char      (rd_char),
    .rd_len       (rd_len)
  );

  lsw_walker u_walker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .rule_symbol   (rule_symbol),
    .char_position (char_position),
    .char_value    (char_value),
    .rule_len      (rule_len),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_symbol    (out_symbol),
    .status        (status),
    .start_symbol  (start_symbol),
    .depth_limit   (depth_limit),
    .wr            (wr),
    .rd            (rd),
    .defined_bits  (defined_bits),
    .rd_char       (rd_char),
    .rd_len        (rd_len)
  );

endmodule
